// ===== design/dns_name_label_encoder_defines.svh =====
// Assertion macros shared by the encoder's top level.
`ifndef DNS_NAME_LABEL_ENCODER_DEFINES_SVH
`define DNS_NAME_LABEL_ENCODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DNLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define DNLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/dnle_pkg.sv =====
`timescale 1ns / 1ps

package dnle_pkg;

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    // Command codes passed from the front end to the back end.
    localparam logic [1:0] CMD_CHAR       = 2'd0;
    localparam logic [1:0] CMD_FLUSH      = 2'd1;
    localparam logic [1:0] CMD_FLUSH_TERM = 2'd2;
    localparam logic [1:0] CMD_TERM       = 2'd3;

    // Command queue geometry.
    localparam int QDEPTH = 2;
    localparam int QAW    = 1;
    localparam int QCW    = 2;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_name;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       name_done;
        logic       label_overflow;
    } t_out;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] chr;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== design/dnle_ram.sv =====
`timescale 1ns / 1ps

module dnle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 62
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/dnle_front.sv =====
`timescale 1ns / 1ps

module dnle_front #(
    parameter int NAME_MAX = 254
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  dnle_pkg::t_in     i_data,
    output logic              o_stall,
    input  dnle_pkg::t_qstat  i_qstat,
    output dnle_pkg::t_push   o_push
);

    localparam int NW = $clog2(NAME_MAX + 1);
    localparam logic [NW-1:0] NAME_LIM = NW'(NAME_MAX);

    logic [NW-1:0] r_name_len, n_name_len;
    logic          r_prev_dot, n_prev_dot;
    logic          acc;

    assign o_stall = i_qstat.full;
    assign acc     = i_valid && !i_qstat.full;

    always_comb begin
        n_name_len     = r_name_len;
        n_prev_dot     = r_prev_dot;
        o_push.valid   = 1'b0;
        o_push.cmd.kind = dnle_pkg::CMD_CHAR;
        o_push.cmd.chr  = i_data.char_byte;
        if (acc) begin
            if (i_data.end_of_name) begin
                o_push.valid = 1'b1;
                if (r_name_len != '0 && !r_prev_dot) begin
                    o_push.cmd.kind = dnle_pkg::CMD_FLUSH_TERM;
                end else begin
                    o_push.cmd.kind = dnle_pkg::CMD_TERM;
                end
                n_name_len = '0;
                n_prev_dot = 1'b0;
            end else if (r_name_len < NAME_LIM) begin
                // Characters past the name limit are silently dropped.
                o_push.valid = 1'b1;
                n_name_len   = r_name_len + NW'(1);
                if (i_data.char_byte == dnle_pkg::DOT_CHAR) begin
                    o_push.cmd.kind = dnle_pkg::CMD_FLUSH;
                    n_prev_dot      = 1'b1;
                end else begin
                    n_prev_dot = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_len <= '0;
            r_prev_dot <= 1'b0;
        end else begin
            r_name_len <= n_name_len;
            r_prev_dot <= n_prev_dot;
        end
    end

endmodule

// ===== design/dnle_queue.sv =====
`timescale 1ns / 1ps

module dnle_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dnle_pkg::t_push   i_push,
    input  logic              i_pop,
    output dnle_pkg::t_cmd    o_head,
    output dnle_pkg::t_qstat  o_qstat
);

    dnle_pkg::t_cmd             r_mem [dnle_pkg::QDEPTH];
    logic [dnle_pkg::QAW-1:0]   r_wp, r_rp;
    logic [dnle_pkg::QCW-1:0]   r_cnt;
    logic                       do_wr, do_rd;

    assign o_qstat.full  = (r_cnt == dnle_pkg::QCW'(dnle_pkg::QDEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign do_wr = i_push.valid && !o_qstat.full;
    assign do_rd = i_pop && !o_qstat.empty;
    assign o_head = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= r_wp + dnle_pkg::QAW'(1);
            end
            if (do_rd) begin
                r_rp <= r_rp + dnle_pkg::QAW'(1);
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + dnle_pkg::QCW'(1);
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - dnle_pkg::QCW'(1);
            end
        end
    end

endmodule

// ===== design/dnle_back.sv =====
`timescale 1ns / 1ps

module dnle_back #(
    parameter int LABEL_MAX = 62
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dnle_pkg::t_cmd    i_cmd,
    input  dnle_pkg::t_qstat  i_qstat,
    output logic              o_pop,
    output logic              o_valid,
    output dnle_pkg::t_out    o_data,
    input  logic              i_stall
);

    localparam int LW = $clog2(LABEL_MAX + 1);
    localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
    localparam logic [LW-1:0] LABEL_LIM = LW'(LABEL_MAX);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LEN  = 2'd1;
    localparam logic [1:0] ST_DATA = 2'd2;
    localparam logic [1:0] ST_TERM = 2'd3;

    logic [1:0]     r_state, n_state;
    logic [LW-1:0]  r_len, n_len;
    logic [LW-1:0]  r_idx, n_idx;
    logic           r_ovf, n_ovf;
    logic           r_term, n_term;
    logic           r_ov;
    dnle_pkg::t_out r_out;

    logic           out_free, load, we;
    dnle_pkg::t_out ld;
    logic [LW-1:0]  last_idx;
    logic [7:0]     rd_data;

    assign out_free = !r_ov || !i_stall;
    assign last_idx = r_len - LW'(1);

    // Read address follows the next index so that the registered read data
    // always matches the current index.
    dnle_ram #(
        .WIDTH(8),
        .DEPTH(LABEL_MAX)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_len[AW-1:0]),
        .i_wdata(i_cmd.chr),
        .i_raddr(n_idx[AW-1:0]),
        .o_rdata(rd_data)
    );

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_idx   = r_idx;
        n_ovf   = r_ovf;
        n_term  = r_term;
        we      = 1'b0;
        o_pop   = 1'b0;
        load    = 1'b0;
        ld      = '0;
        case (r_state)
            ST_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop = 1'b1;
                    case (i_cmd.kind)
                        dnle_pkg::CMD_CHAR: begin
                            if (r_len < LABEL_LIM) begin
                                we    = 1'b1;
                                n_len = r_len + LW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        dnle_pkg::CMD_FLUSH: begin
                            n_term  = 1'b0;
                            n_idx   = '0;
                            n_state = ST_LEN;
                        end
                        dnle_pkg::CMD_FLUSH_TERM: begin
                            n_term  = 1'b1;
                            n_idx   = '0;
                            n_state = ST_LEN;
                        end
                        dnle_pkg::CMD_TERM: begin
                            n_state = ST_TERM;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LEN: begin
                if (out_free) begin
                    load              = 1'b1;
                    ld.out_byte       = 8'(r_len);
                    ld.last_of_run    = (r_len == '0) && !r_term;
                    ld.label_overflow = r_ovf;
                    if (r_len == '0) begin
                        n_ovf   = 1'b0;
                        n_state = r_term ? ST_TERM : ST_IDLE;
                    end else begin
                        n_state = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                if (out_free) begin
                    load              = 1'b1;
                    ld.out_byte       = rd_data;
                    ld.last_of_run    = (r_idx == last_idx) && !r_term;
                    ld.label_overflow = r_ovf;
                    if (r_idx == last_idx) begin
                        n_len   = '0;
                        n_ovf   = 1'b0;
                        n_state = r_term ? ST_TERM : ST_IDLE;
                    end else begin
                        n_idx = r_idx + LW'(1);
                    end
                end
            end
            ST_TERM: begin
                if (out_free) begin
                    load           = 1'b1;
                    ld.last_of_run = 1'b1;
                    ld.name_done   = 1'b1;
                    n_len          = '0;
                    n_ovf          = 1'b0;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len   <= '0;
            r_idx   <= '0;
            r_ovf   <= 1'b0;
            r_term  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_ovf   <= n_ovf;
            r_term  <= n_term;
            if (load) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= ld;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

// ===== design/dns_name_label_encoder.sv =====
`timescale 1ns / 1ps
// Encodes a dotted domain name into DNS wire format, one character per request.
// Input channel: i_valid, i_data (char_byte, end_of_name), o_stall. A request
// is taken at a rising edge with i_valid high and o_stall low. A dot sends the
// current label as its length byte and its characters; an end-of-name request
// sends the pending label (unless the name ended on a dot) and a zero byte.
// Output channel: o_valid, o_data, i_stall. During a flush, one result byte
// per cycle while the receiver does not stall; last_of_run marks the final
// byte of a request. Each character is written into the label store when its
// command is taken and read back out on flush; length bytes and terminators
// come from the back end's own states. The label store has one write and one
// read port. With the queue empty and the back end idle, the first byte of a
// flush goes through the queue, the back end's length state and the output
// register before o_valid rises. A two-entry command queue sits between the
// front end and the back end, so input is taken while the back end is flushing.
// Reset (synchronous, active low) empties the queue and clears the name and
// label state. When the receiver stalls, the output holds; the back end then
// stops, the queue fills and o_stall rises.
`include "dns_name_label_encoder_defines.svh"

module dns_name_label_encoder #(
    parameter int LABEL_MAX = 62,
    parameter int NAME_MAX  = 254
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  dnle_pkg::t_in   i_data,
    output logic            o_stall,
    output logic            o_valid,
    output dnle_pkg::t_out  o_data,
    input  logic            i_stall
);

    dnle_pkg::t_push  push;
    dnle_pkg::t_cmd   head;
    dnle_pkg::t_qstat qstat;
    logic             pop;

    // Front end: counts name characters, drops excess ones and turns each
    // request that it keeps into a command.
    dnle_front #(
        .NAME_MAX(NAME_MAX)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_data (i_data),
        .o_stall(o_stall),
        .i_qstat(qstat),
        .o_push (push)
    );

    dnle_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_pop  (pop),
        .o_head (head),
        .o_qstat(qstat)
    );

    // Back end: stores label characters and sequences the wire-format bytes.
    dnle_back #(
        .LABEL_MAX(LABEL_MAX)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (head),
        .i_qstat(qstat),
        .o_pop  (pop),
        .o_valid(o_valid),
        .o_data (o_data),
        .i_stall(i_stall)
    );

    // The terminator always closes its request and carries no overflow flag.
    `DNLE_ASSERT_NOW(a_term_last, o_valid && o_data.name_done, o_data.last_of_run && !o_data.label_overflow && o_data.out_byte == 8'd0, "terminator malformed")
    // The queue can never be both full and empty.
    `DNLE_ASSERT_NOW(a_queue_sane, 1'b1, !(qstat.full && qstat.empty), "queue status inconsistent")
    // The input side stalls only when the queue is full.
    `DNLE_ASSERT_NOW(a_stall_full, o_stall, qstat.full, "stall without full queue")

endmodule

// ===== dv/dns_name_label_encoder_tb.sv =====
`timescale 1ns / 1ps

module dns_name_label_encoder_tb;

    import dnle_pkg::*;

    // Block parameters; the instance below uses the same values.
    localparam int LABEL_MAX = 62;
    localparam int NAME_MAX  = 254;

    // Run control. The cycle limit is far above the slowest legal run:
    // roughly 350 requests with sender gaps, one long hold-off and a
    // receiver that stalls with odds of three in four for long stretches.
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 32;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 60;
    localparam int TOTAL_ITEMS  = 350;
    localparam int MAX_REPORTS  = 10;

    // Receiver stall patterns. Each one runs for a random stretch of cycles.
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    t_in  i_data  = '0;
    logic o_stall;
    logic o_valid;
    t_out o_data;
    logic i_stall = 1'b0;

    always #1 i_clk = ~i_clk;

    dns_name_label_encoder #(
        .LABEL_MAX(LABEL_MAX),
        .NAME_MAX (NAME_MAX)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_data (i_data),
        .o_stall(o_stall),
        .o_valid(o_valid),
        .o_data (o_data),
        .i_stall(i_stall)
    );

    // Requests waiting to be driven, and the wire-format bytes that the
    // accepted requests must still produce, oldest first.
    t_in  name_chars_q[$];
    t_out wire_bytes_q[$];

    int n_items    = 0;
    int n_accepted = 0;
    int n_fail     = 0;
    int cycle_cnt  = 0;

    // Encoder state as the testbench sees it. It follows every accepted
    // request and is never reset again after the start of the run.
    logic [7:0] label_chars [LABEL_MAX];
    int         label_len   = 0;
    int         name_len    = 0;
    logic       prev_dot    = 1'b0;
    logic       label_ovf   = 1'b0;

    // Sends the current label as its length byte and its characters, then
    // clears the label. When the flush is the last output of the request,
    // its final byte carries last_of_run.
    function automatic void flush_label(input logic mark_last);
        t_out b;
        for (int i = 0; i <= label_len; i++) begin
            b.out_byte       = (i == 0) ? 8'(label_len) : label_chars[i - 1];
            b.last_of_run    = mark_last && (i == label_len);
            b.name_done      = 1'b0;
            b.label_overflow = label_ovf;
            wire_bytes_q.push_back(b);
        end
        label_len = 0;
        label_ovf = 1'b0;
    endfunction

    // Works out the wire-format bytes caused by one accepted request.
    function automatic void encode_request(input t_in req);
        t_out term;
        if (req.end_of_name) begin
            // A name that ended on a dot has already sent its last label.
            if (name_len != 0 && !prev_dot) begin
                flush_label(1'b0);
            end
            term.out_byte       = 8'h00;
            term.last_of_run    = 1'b1;
            term.name_done      = 1'b1;
            term.label_overflow = 1'b0;
            wire_bytes_q.push_back(term);
            label_len = 0;
            name_len  = 0;
            prev_dot  = 1'b0;
            label_ovf = 1'b0;
        end else if (name_len < NAME_MAX) begin
            // Past the name limit, characters and dots alike are dropped
            // without touching any state until the end of the name.
            name_len++;
            if (req.char_byte == DOT_CHAR) begin
                flush_label(1'b1);
                prev_dot = 1'b1;
            end else begin
                prev_dot = 1'b0;
                if (label_len < LABEL_MAX) begin
                    label_chars[label_len] = req.char_byte;
                    label_len++;
                end else begin
                    label_ovf = 1'b1;
                end
            end
        end
    endfunction

    // Any byte but a dot, for use inside a label.
    function automatic logic [7:0] label_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == DOT_CHAR);
        return c;
    endfunction

    task automatic add_char(input logic [7:0] c);
        t_in req;
        req.char_byte   = c;
        req.end_of_name = 1'b0;
        name_chars_q.push_back(req);
        n_items++;
    endtask

    // The character field of an end request is ignored, so it is random.
    task automatic add_end();
        t_in req;
        req.char_byte   = 8'($urandom_range(0, 255));
        req.end_of_name = 1'b1;
        name_chars_q.push_back(req);
        n_items++;
    endtask

    task automatic add_label(input int len);
        repeat (len) add_char(label_char());
    endtask

    task automatic report_failure(input string what, input logic have_want,
                                  input t_out want, input t_out got);
        n_fail++;
        if (n_fail <= MAX_REPORTS) begin
            if (have_want) begin
                $display("%0d: %s: expected byte %02h last %b done %b ovf %b, got byte %02h last %b done %b ovf %b",
                         cycle_cnt, what, want.out_byte, want.last_of_run,
                         want.name_done, want.label_overflow, got.out_byte,
                         got.last_of_run, got.name_done, got.label_overflow);
            end else begin
                $display("%0d: %s: byte %02h last %b done %b ovf %b", cycle_cnt, what,
                         got.out_byte, got.last_of_run, got.name_done, got.label_overflow);
            end
        end
    endtask

    // Request driver. It sends in bursts of random length separated by random
    // gaps. A request that is stalled stays on the bus unchanged, and valid is
    // decided without looking at the stall except to hold the current request.
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                encode_request(i_data);
                n_accepted <= n_accepted + 1;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (name_chars_q.size() > 0) begin
                    i_valid <= 1'b1;
                    i_data  <= name_chars_q.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        // About one burst in four runs straight into the next.
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off: once some requests have gone through, the receiver
    // stalls for a fixed stretch while the sender keeps offering requests,
    // so the command queue fills and the block must stall its input.
    logic hold_on     = 1'b0;
    logic hold_done   = 1'b0;
    int   hold_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_on     <= 1'b0;
            hold_done   <= 1'b0;
            hold_cycles <= 0;
        end else if (!hold_done && n_accepted >= HOLD_AFTER) begin
            hold_on     <= 1'b1;
            hold_done   <= 1'b1;
            hold_cycles <= HOLD_CYCLES;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            if (hold_cycles == 1) begin
                hold_on <= 1'b0;
            end
        end
    end

    // Receiver stall pattern. Every stretch picks a new mode, so there are
    // runs with no stall at all as well as light, heavy and alternating ones.
    t_stall_mode stall_mode  = STALL_NONE;
    int          phase_left  = 0;
    logic        stall_bit   = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                phase_left = $urandom_range(16, 96);
            end else begin
                phase_left--;
            end
            case (stall_mode)
                STALL_NONE:  stall_bit = 1'b0;
                STALL_LIGHT: stall_bit = ($urandom_range(0, 3) == 0);
                STALL_HEAVY: stall_bit = ($urandom_range(0, 3) != 0);
                default:     stall_bit = ~stall_bit;
            endcase
            i_stall <= hold_on || stall_bit;
        end
    end

    // Result checker. Every accepted byte is matched against the oldest
    // expected one, field by field.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (wire_bytes_q.size() == 0) begin
                report_failure("unexpected byte", 1'b0, o_data, o_data);
            end else begin
                want = wire_bytes_q.pop_front();
                if (o_data.out_byte !== want.out_byte ||
                    o_data.last_of_run !== want.last_of_run ||
                    o_data.name_done !== want.name_done ||
                    o_data.label_overflow !== want.label_overflow) begin
                    report_failure("mismatch", 1'b1, want, o_data);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("dns_name_label_encoder_tb NOT OK");
            $finish;
        end
    end

    initial begin
        int n_labels;
        int len;
        int name_chars;
        int r;

        // Directed names. The root name, a zero byte and an all-ones byte as
        // label characters, a leading dot and two dots in a row (both give
        // empty labels), a trailing dot that must be dropped, a name made of
        // a lone dot, and an end request whose character field is a dot.
        add_end();
        add_char(8'h00);
        add_char(8'hFF);
        add_char(DOT_CHAR);
        add_char(8'h41);
        add_end();
        add_char(DOT_CHAR);
        add_char(DOT_CHAR);
        add_char(8'h62);
        add_end();
        add_char(8'h63);
        add_char(DOT_CHAR);
        add_end();
        add_char(DOT_CHAR);
        add_end();
        add_char(8'h64);
        name_chars_q.push_back('{char_byte: DOT_CHAR, end_of_name: 1'b1});
        n_items++;

        // One long name. Its first label has exactly the maximum length and
        // its second runs over it and is flushed by a dot. The third label
        // runs past both the label and the name limit: characters and dots
        // after the name limit are dropped, and the end request still sends
        // the third label, cut to the maximum length, and closes the name.
        add_label(LABEL_MAX);
        add_char(DOT_CHAR);
        len = LABEL_MAX + $urandom_range(1, 8);
        add_label(len);
        add_char(DOT_CHAR);
        name_chars = LABEL_MAX + len + 2;
        add_label(NAME_MAX - name_chars + 12);
        add_char(DOT_CHAR);
        add_label(3);
        add_end();

        // Random part. Most of it is well-formed names with random labels;
        // now and then a label runs long, is empty, or the name ends on a
        // dot. The rest is noise with dots and end requests anywhere.
        while (n_items < TOTAL_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 8)) begin
                    r = $urandom_range(0, 11);
                    if (r < 2) begin
                        add_end();
                    end else if (r < 5) begin
                        add_char(DOT_CHAR);
                    end else begin
                        add_char(8'($urandom_range(0, 255)));
                    end
                end
            end else begin
                n_labels = $urandom_range(0, 4);
                for (int j = 0; j < n_labels; j++) begin
                    r = $urandom_range(0, 19);
                    if (r == 0) begin
                        len = 0;
                    end else if (r == 1) begin
                        len = $urandom_range(LABEL_MAX - 2, LABEL_MAX + 4);
                    end else begin
                        len = $urandom_range(1, 12);
                    end
                    if (j > 0) begin
                        add_char(DOT_CHAR);
                    end
                    add_label(len);
                end
                if ($urandom_range(0, 3) == 0) begin
                    add_char(DOT_CHAR);
                end
                add_end();
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every request has been taken and every expected byte
        // has come out, checking between edges so nothing races the driver.
        do begin
            @(negedge i_clk);
        end while (name_chars_q.size() != 0 || i_valid || wire_bytes_q.size() != 0);

        // Give any stray output time to show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("dns_name_label_encoder_tb OK");
        end else begin
            $display("dns_name_label_encoder_tb NOT OK");
        end
        $finish;
    end

endmodule
